>>> hw/rtl/sst_pkg.sv
// Package for the step sequencer trigger block: widths, register indexes,
// sequencer state codes and hash constants. No dependencies.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int unsigned Channels     = 16;
  localparam int unsigned MaxSteps     = 64;
  localparam int unsigned PosBits      = 48;
  localparam int unsigned ChBits       = 4;
  localparam int unsigned StepBits     = 6;
  localparam int unsigned AddrBits     = ChBits + StepBits;
  localparam int unsigned EntryBits    = 19;
  localparam int unsigned LenBits      = 31;
  localparam int unsigned CntBits      = 6;
  localparam int unsigned InDataBits   = 80;
  localparam int unsigned OutDataBits  = 80;

  localparam logic [31:0] SpsReset     = 32'd1536000;
  localparam logic [6:0]  NumStepsReset = 7'd16;
  localparam logic [6:0]  MaxStepsVal  = 7'd64;

  localparam logic [31:0] HashCh       = 32'd374761393;
  localparam logic [31:0] HashStep     = 32'd668265263;
  localparam logic [9:0]  ProbFull     = 10'd1000;
  // floor(2^32 / 1000): quotient estimate is exact or one low
  localparam logic [22:0] RecipK       = 23'd4294967;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_SPS      = 3'd1,
    REG_NSTEPS   = 3'd2,
    REG_VALID    = 3'd3,
    REG_MUTE     = 3'd4,
    REG_SOLO     = 3'd5
  } reg_idx_e;

  typedef enum logic [0:0] {
    OP_TICK  = 1'b0,
    OP_WRITE = 1'b1
  } opcode_e;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LEN   = 12'b000000000010,
    S_DINIT = 12'b000000000100,
    S_DIV1  = 12'b000000001000,
    S_DIV2  = 12'b000000010000,
    S_START = 12'b000000100000,
    S_SCAN  = 12'b000001000000,
    S_HASH  = 12'b000010000000,
    S_MUL   = 12'b000100000000,
    S_DEC   = 12'b001000000000,
    S_NEXT  = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

endpackage

>>> hw/rtl/step_sequencer_trigger.sv
// Step sequencer trigger top level: step table memory, shared restoring
// divider and per-channel probability scan. Uses sst_pkg.
`timescale 1ns / 1ps

// Usage:
//  s_axis: one request per handshake. tuser = opcode (0 tick, 1 table write).
//  m_axis: result stream. tuser = fired, tlast marks the last result of a
//  request. A write, or a tick that fires nothing, gives one status result;
//  a firing tick gives one result per triggered channel, lowest channel first.
//  cfg_*: register writes, only while the block is idle.
//  One request at a time. A write presents its result in the cycle after
//  acceptance. A playing tick on an enabled block runs the pattern length
//  multiply, two 48-bit divisions on the shared divider (loop cycle, then
//  step index) and a start check; a firing step then scans the 16 channels,
//  an eligible channel also passing through hash, multiply and decide states,
//  with one output state per result. s_axis_tready is high only when idle.
//  Reset: registers take their reset values, current step reads -1; the step
//  table is not cleared and must be written before use.
//  A stalled receiver holds the block in its output state; nothing is lost.
module step_sequencer_trigger (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_position[47:0], transport_playing[48], channel_sel[52:49],
  // step_sel[58:53], step_active[59], probability[69:60], velocity_in[77:70]
  input  logic [79:0] s_axis_tdata,
  // opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // trig_channel[3:0], trig_step[9:4], trig_velocity[17:10],
  // current_step[24:18], loop_cycle[72:25]
  output logic [79:0] m_axis_tdata,
  // fired
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  sst_pkg::state_e state_q, state_d;

  // configuration
  logic        enable_q;
  logic [31:0] sps_q;
  logic [6:0]  nsteps_q;
  logic [15:0] valid_q, mute_q, solo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      sps_q    <= sst_pkg::SpsReset;
      nsteps_q <= sst_pkg::NumStepsReset;
      valid_q  <= '0;
      mute_q   <= '0;
      solo_q   <= '0;
    end else if (cfg_we_i) begin
      case (sst_pkg::reg_idx_e'(cfg_idx_i))
        sst_pkg::REG_ENABLE: enable_q <= cfg_data_i[0];
        sst_pkg::REG_SPS:    sps_q    <= cfg_data_i;
        sst_pkg::REG_NSTEPS: nsteps_q <= cfg_data_i[6:0];
        sst_pkg::REG_VALID:  valid_q  <= cfg_data_i[15:0];
        sst_pkg::REG_MUTE:   mute_q   <= cfg_data_i[15:0];
        sst_pkg::REG_SOLO:   solo_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [47:0] in_pos;
  logic        in_play;
  logic [3:0]  in_ch;
  logic [5:0]  in_step;
  logic        in_act;
  logic [9:0]  in_prob;
  logic [7:0]  in_vel;
  assign in_pos  = s_axis_tdata[47:0];
  assign in_play = s_axis_tdata[48];
  assign in_ch   = s_axis_tdata[52:49];
  assign in_step = s_axis_tdata[58:53];
  assign in_act  = s_axis_tdata[59];
  assign in_prob = s_axis_tdata[69:60];
  assign in_vel  = s_axis_tdata[77:70];

  logic s_fire;
  assign s_axis_tready = (state_q == sst_pkg::S_IDLE);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // step table
  logic [sst_pkg::EntryBits-1:0] mem [1 << sst_pkg::AddrBits];
  logic [sst_pkg::EntryBits-1:0] rd_q;
  logic [sst_pkg::AddrBits-1:0]  rd_addr;
  logic                          wr_en;

  assign wr_en = s_fire && (s_axis_tuser == sst_pkg::OP_WRITE);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{in_ch, in_step}] <= {in_act, in_prob, in_vel};
    end
    rd_q <= mem[rd_addr];
  end

  // sequencer state
  logic [47:0]               pos_q, pos_d;
  logic [sst_pkg::LenBits-1:0] len_q, len_d;
  logic [47:0]               dq_q, dq_d;      // dividend / quotient shift reg
  logic [32:0]               rem_q, rem_d;
  logic [31:0]               dvs_q, dvs_d;
  logic [sst_pkg::CntBits-1:0] cnt_q, cnt_d;
  logic [47:0]               cyc_q, cyc_d;
  logic [sst_pkg::LenBits-1:0] pin_q, pin_d;
  logic [5:0]                step_q, step_d;
  logic [3:0]                ch_q, ch_d;
  logic [6:0]                last_step_q, last_step_d;
  logic [47:0]               last_cyc_q, last_cyc_d;
  logic [6:0]                shown_q, shown_d;
  logic [31:0]               h_q, h_d;
  logic [22:0]               quo_q, quo_d;
  logic                      pend_q, pend_d;
  logic [3:0]                pend_ch_q, pend_ch_d;
  logic [7:0]                pend_vel_q, pend_vel_d;
  logic                      o_fired_q, o_fired_d;
  logic [3:0]                o_ch_q, o_ch_d;
  logic [7:0]                o_vel_q, o_vel_d;
  logic                      o_last_q, o_last_d;

  // combinational helpers
  logic [6:0]  nst_eff;
  logic [38:0] len_prod;
  logic [32:0] rem_sh;
  logic        div_bit;
  logic [32:0] rem_sub;
  logic [37:0] start_prod;
  logic        ch_ok;
  logic [31:0] cyc32, h_raw;
  logic [54:0] quo_prod;
  logic [32:0] r1;
  logic [31:0] r2;
  logic [9:0]  ent_prob;
  logic        pass;

  always_comb begin
    nst_eff    = (nsteps_q > sst_pkg::MaxStepsVal) ? sst_pkg::MaxStepsVal : nsteps_q;
    len_prod   = 39'(sps_q) * 39'(nst_eff);
    rem_sh     = {rem_q[31:0], dq_q[47]};
    div_bit    = (rem_sh >= {1'b0, dvs_q});
    rem_sub    = div_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    start_prod = 38'(step_q) * 38'(sps_q);
    ch_ok      = valid_q[ch_q] && !mute_q[ch_q] && ((solo_q == '0) || solo_q[ch_q]);
    cyc32      = cyc_q[31:0];
    h_raw      = (32'(ch_q) * sst_pkg::HashCh) + (32'(step_q) * sst_pkg::HashStep)
                 + ({cyc32[0], 31'b0} - cyc32);
    quo_prod   = 55'(h_q) * 55'(sst_pkg::RecipK);
    r1         = {1'b0, h_q} - (33'(quo_q) * 33'(sst_pkg::ProbFull));
    r2         = (r1 >= 33'(sst_pkg::ProbFull)) ? 32'(r1 - 33'(sst_pkg::ProbFull))
                                                : r1[31:0];
    ent_prob   = rd_q[17:8];
    pass       = (ent_prob >= sst_pkg::ProbFull) ||
                 ((ent_prob != '0) && (r2 < 32'(ent_prob)));
    rd_addr    = {ch_q, step_q};
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    len_d       = len_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    cnt_d       = cnt_q;
    cyc_d       = cyc_q;
    pin_d       = pin_q;
    step_d      = step_q;
    ch_d        = ch_q;
    last_step_d = last_step_q;
    last_cyc_d  = last_cyc_q;
    shown_d     = shown_q;
    h_d         = h_q;
    quo_d       = quo_q;
    pend_d      = pend_q;
    pend_ch_d   = pend_ch_q;
    pend_vel_d  = pend_vel_q;
    o_fired_d   = o_fired_q;
    o_ch_d      = o_ch_q;
    o_vel_d     = o_vel_q;
    o_last_d    = o_last_q;

    case (state_q)
      sst_pkg::S_IDLE: begin
        if (s_fire) begin
          pos_d     = in_pos;
          o_fired_d = 1'b0;
          o_ch_d    = '0;
          o_vel_d   = '0;
          o_last_d  = 1'b1;
          step_d    = '0;
          if (s_axis_tuser == sst_pkg::OP_WRITE) begin
            state_d = sst_pkg::S_OUT;
          end else if (!in_play || !enable_q) begin
            shown_d = '1;
            state_d = sst_pkg::S_OUT;
          end else begin
            state_d = sst_pkg::S_LEN;
          end
        end
      end
      sst_pkg::S_LEN: begin
        len_d   = len_prod[38:8];
        state_d = sst_pkg::S_DINIT;
      end
      sst_pkg::S_DINIT: begin
        dq_d  = pos_q;
        rem_d = '0;
        dvs_d = 32'(len_q);
        cnt_d = '0;
        state_d = (len_q == '0) ? sst_pkg::S_OUT : sst_pkg::S_DIV1;
      end
      sst_pkg::S_DIV1, sst_pkg::S_DIV2: begin
        dq_d  = {dq_q[46:0], div_bit};
        rem_d = rem_sub;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == sst_pkg::CntBits'(47)) begin
          if (state_q == sst_pkg::S_DIV1) begin
            cyc_d = {dq_q[46:0], div_bit};
            pin_d = rem_sub[sst_pkg::LenBits-1:0];
            dq_d  = {9'b0, rem_sub[sst_pkg::LenBits-1:0], 8'b0};
            rem_d = '0;
            dvs_d = sps_q;
            cnt_d = '0;
            state_d = sst_pkg::S_DIV2;
          end else begin
            step_d  = div_bit ? {dq_q[4:0], 1'b1} : {dq_q[4:0], 1'b0};
            state_d = sst_pkg::S_START;
          end
        end
      end
      sst_pkg::S_START: begin
        if ((32'(start_prod[37:8]) == 32'(pin_q)) &&
            !(({1'b0, step_q} == last_step_q) && (cyc_q == last_cyc_q))) begin
          last_step_d = {1'b0, step_q};
          last_cyc_d  = cyc_q;
          shown_d     = {1'b0, step_q};
          ch_d        = '0;
          pend_d      = 1'b0;
          state_d     = sst_pkg::S_SCAN;
        end else begin
          state_d = sst_pkg::S_OUT;
        end
      end
      sst_pkg::S_SCAN: begin
        // table read issued this cycle for every channel; only eligible ones go on
        if (ch_ok) begin
          state_d = sst_pkg::S_HASH;
        end else begin
          state_d = sst_pkg::S_NEXT;
        end
      end
      sst_pkg::S_HASH: begin
        h_d     = h_raw ^ {13'b0, h_raw[31:13]};
        state_d = sst_pkg::S_MUL;
      end
      sst_pkg::S_MUL: begin
        quo_d   = quo_prod[54:32];
        state_d = sst_pkg::S_DEC;
      end
      sst_pkg::S_DEC: begin
        state_d = sst_pkg::S_NEXT;
        if (rd_q[18] && pass) begin
          pend_d     = 1'b1;
          pend_ch_d  = ch_q;
          pend_vel_d = rd_q[7:0];
          if (pend_q) begin
            o_fired_d = 1'b1;
            o_ch_d    = pend_ch_q;
            o_vel_d   = pend_vel_q;
            o_last_d  = 1'b0;
            state_d   = sst_pkg::S_OUT;
          end
        end
      end
      sst_pkg::S_NEXT: begin
        if (ch_q == 4'd15) begin
          o_last_d = 1'b1;
          if (pend_q) begin
            o_fired_d = 1'b1;
            o_ch_d    = pend_ch_q;
            o_vel_d   = pend_vel_q;
          end else begin
            o_fired_d = 1'b0;
            o_ch_d    = '0;
            o_vel_d   = '0;
            step_d    = '0;
          end
          state_d = sst_pkg::S_OUT;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = sst_pkg::S_SCAN;
        end
      end
      sst_pkg::S_OUT: begin
        if (m_axis_tready) begin
          state_d = o_last_q ? sst_pkg::S_IDLE : sst_pkg::S_NEXT;
        end
      end
      default: state_d = sst_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sst_pkg::S_IDLE;
      last_step_q <= '1;
      last_cyc_q  <= '0;
      shown_q     <= '1;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_step_q <= last_step_d;
      last_cyc_q  <= last_cyc_d;
      shown_q     <= shown_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    len_q      <= len_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    dvs_q      <= dvs_d;
    cnt_q      <= cnt_d;
    cyc_q      <= cyc_d;
    pin_q      <= pin_d;
    step_q     <= step_d;
    ch_q       <= ch_d;
    h_q        <= h_d;
    quo_q      <= quo_d;
    pend_ch_q  <= pend_ch_d;
    pend_vel_q <= pend_vel_d;
    o_fired_q  <= o_fired_d;
    o_ch_q     <= o_ch_d;
    o_vel_q    <= o_vel_d;
    o_last_q   <= o_last_d;
  end

  assign m_axis_tvalid = (state_q == sst_pkg::S_OUT);
  assign m_axis_tuser  = o_fired_q;
  assign m_axis_tlast  = o_last_q;
  assign m_axis_tdata  = {7'b0, last_cyc_q, shown_q, o_vel_q,
                          (o_fired_q ? step_q : 6'b0), o_ch_q};

endmodule

>>> tb/sv/tb.sv
// Testbench for step_sequencer_trigger: table writes and sample ticks go in,
// triggers and status come out and are checked against an in-bench predictor.
// Depends on sst_pkg and the step_sequencer_trigger RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned RandItems  = 14;  // per phase, 8 phases
  // channels whose entries are written for every step
  localparam logic [15:0] FillMask   = 16'h8001;

  typedef struct packed {
    sst_pkg::opcode_e op;
    logic [47:0] pos;
    logic        play;
    logic [3:0]  ch;
    logic [5:0]  st;
    logic        act;
    logic [9:0]  prob;
    logic [7:0]  vel;
  } seq_req_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  ch;
    logic [5:0]  st;
    logic [7:0]  vel;
    logic [6:0]  cur;
    logic [47:0] cyc;
    logic        last;
  } trig_t;

  typedef struct {
    seq_req_t    req;
    bit          typed;
    logic [6:0]  cur;
    logic [47:0] cyc;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser, m_axis_tlast;
  logic [79:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  step_sequencer_trigger uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the block state
  logic        en_m;
  logic [31:0] sps_m;
  logic [6:0]  nst_m;
  logic [15:0] valid_m, mute_m, solo_m;
  logic [18:0] pattern_m [0:1023];
  logic [6:0]  last_step_m, shown_m;
  logic [47:0] last_cyc_m;

  trig_t trig_q[$];
  int    errors = 0;
  int    idle_pct_s = 0, idle_pct_r = 0;
  int    quiet_cycles = 0;

  function automatic bit chance_pass(logic [9:0] prob, logic [3:0] ch, logic [5:0] st,
                                     logic [47:0] cyc);
    logic [31:0] h;
    if (prob >= sst_pkg::ProbFull) return 1'b1;
    if (prob == 0) return 1'b0;
    h = {28'd0, ch} * sst_pkg::HashCh + {26'd0, st} * sst_pkg::HashStep
        + cyc[31:0] * 32'd2147483647;
    h = h ^ (h >> 13);
    return (h % 32'd1000) < {22'd0, prob};
  endfunction

  function automatic logic [63:0] pattern_len();
    logic [63:0] n;
    n = (nst_m > sst_pkg::MaxStepsVal) ? 64'd64 : {57'd0, nst_m};
    return ({32'd0, sps_m} * n) >> 8;
  endfunction

  function automatic void predict_triggers(seq_req_t r);
    logic [63:0] len, pin, cyc, stp, start;
    logic [18:0] e;
    trig_t t;
    int n;
    n = 0;
    if (r.op == sst_pkg::OP_WRITE) begin
      pattern_m[{r.ch, r.st}] = {r.act, r.prob, r.vel};
    end else if (!r.play || !en_m) begin
      shown_m = 7'h7f;
    end else begin
      len = pattern_len();
      if (sps_m != 0 && nst_m != 0 && len != 0) begin
        pin   = {16'd0, r.pos} % len;
        cyc   = {16'd0, r.pos} / len;
        stp   = (pin << 8) / {32'd0, sps_m};
        start = (stp * {32'd0, sps_m}) >> 8;
        if (pin == start && !(stp[6:0] == last_step_m && cyc[47:0] == last_cyc_m)) begin
          last_step_m = stp[6:0];
          last_cyc_m  = cyc[47:0];
          shown_m     = stp[6:0];
          for (int c = 0; c < 16; c++) begin
            if (!valid_m[c] || mute_m[c]) continue;
            if (solo_m != 0 && !solo_m[c]) continue;
            e = pattern_m[{c[3:0], stp[5:0]}];
            if (!e[18]) continue;
            if (!chance_pass(e[17:8], c[3:0], stp[5:0], cyc[47:0])) continue;
            t = '{1'b1, c[3:0], stp[5:0], e[7:0], shown_m, last_cyc_m, 1'b0};
            trig_q.push_back(t);
            n++;
          end
        end
      end
    end
    if (n == 0) begin
      t = '{1'b0, 4'd0, 6'd0, 8'd0, shown_m, last_cyc_m, 1'b0};
      trig_q.push_back(t);
    end
    trig_q[trig_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [47:0] e, logic [47:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endfunction

  // result side: random stall, compare, watchdog
  always @(posedge clk_i) begin
    trig_t e;
    m_axis_tready <= ($urandom_range(99) >= idle_pct_r);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WatchLimit) begin
      $display("[step_sequencer_trigger] ERROR");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (trig_q.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        e = trig_q.pop_front();
        check_field("fired", 48'(e.fired), 48'(m_axis_tuser));
        check_field("trig_channel", 48'(e.ch), 48'(m_axis_tdata[3:0]));
        check_field("trig_step", 48'(e.st), 48'(m_axis_tdata[9:4]));
        check_field("trig_velocity", 48'(e.vel), 48'(m_axis_tdata[17:10]));
        check_field("current_step", 48'(e.cur), 48'(m_axis_tdata[24:18]));
        check_field("loop_cycle", e.cyc, m_axis_tdata[72:25]);
        check_field("last_result", 48'(e.last), 48'(m_axis_tlast));
      end
    end
  end

  task automatic send_req(seq_req_t r);
    while ($urandom_range(99) < idle_pct_s) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {2'b0, r.vel, r.prob, r.act, r.st, r.ch, r.play, r.pos};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_triggers(r);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (trig_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic put_reg(sst_pkg::reg_idx_e idx, logic [31:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
  endtask

  task automatic set_regs(bit en, logic [31:0] sps, logic [6:0] nst,
                          logic [15:0] vm, logic [15:0] mm, logic [15:0] sm);
    drain();
    put_reg(sst_pkg::REG_ENABLE, {31'd0, en});
    put_reg(sst_pkg::REG_SPS, sps);
    put_reg(sst_pkg::REG_NSTEPS, {25'd0, nst});
    put_reg(sst_pkg::REG_VALID, {16'd0, vm});
    put_reg(sst_pkg::REG_MUTE, {16'd0, mm});
    put_reg(sst_pkg::REG_SOLO, {16'd0, sm});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    en_m = en; sps_m = sps; nst_m = nst; valid_m = vm; mute_m = mm; solo_m = sm;
  endtask

  function automatic seq_req_t tick_at(logic [47:0] pos, logic play);
    seq_req_t r;
    r = '0;
    r.op = sst_pkg::OP_TICK; r.pos = pos; r.play = play;
    return r;
  endfunction

  function automatic seq_req_t entry_wr(logic [3:0] ch, logic [5:0] st, logic act,
                                        logic [9:0] prob, logic [7:0] vel);
    seq_req_t r;
    r = '0;
    r.op = sst_pkg::OP_WRITE; r.ch = ch; r.st = st; r.act = act; r.prob = prob;
    r.vel = vel;
    r.pos = 48'({$urandom, $urandom});
    r.play = 1'($urandom);
    return r;
  endfunction

  function automatic logic [9:0] rand_prob();
    case ($urandom_range(3))
      0: return 10'd0;
      1: return sst_pkg::ProbFull;
      default: return 10'($urandom_range(1000));
    endcase
  endfunction

  // mostly ticks landing exactly on a step start, the rest noise
  function automatic seq_req_t rand_req(logic [47:0] prev_pos);
    logic [63:0] len, nst, cyc, stp;
    seq_req_t r;
    len = pattern_len();
    nst = (nst_m > sst_pkg::MaxStepsVal) ? 64'd64 : {57'd0, nst_m};
    case ($urandom_range(9))
      0, 1: r = entry_wr(4'($urandom), 6'($urandom), 1'($urandom), rand_prob(),
                         8'($urandom));
      2:    r = tick_at(48'({$urandom, $urandom}), $urandom_range(3) != 0);
      3:    r = tick_at(prev_pos, 1'b1);
      default: begin
        if (len == 0 || nst == 0 || sps_m == 0) begin
          r = tick_at(48'({$urandom, $urandom}), 1'b1);
        end else begin
          stp = 64'($urandom_range(32'(nst - 1)));
          cyc = ($urandom_range(1) != 0) ? 64'($urandom_range(3))
                                         : ({$urandom, $urandom} & 64'hffff_ffff_ffff) / len;
          r = tick_at(48'(cyc * len + ((stp * sps_m) >> 8)), $urandom_range(15) != 0);
        end
      end
    endcase
    return r;
  endfunction

  initial begin
    dir_row_t rows_a [4];
    dir_row_t rows_b [10];
    seq_req_t r;
    logic [47:0] prev_pos;

    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0; s_axis_tuser <= 1'b0; s_axis_tdata <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i <= 1'b0; cfg_idx_i <= sst_pkg::REG_ENABLE; cfg_data_i <= '0;
    en_m = 0; sps_m = sst_pkg::SpsReset; nst_m = sst_pkg::NumStepsReset;
    valid_m = 0; mute_m = 0; solo_m = 0;
    last_step_m = 7'h7f; shown_m = 7'h7f; last_cyc_m = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // channels 0 and 15 get every step; random phases only enable those two
    for (int a = 0; a < 128; a++)
      send_req(entry_wr(a[6] ? 4'd15 : 4'd0, a[5:0], 1'($urandom), rand_prob(),
                        8'($urandom)));
    drain();

    // after reset and with no valid channels: status only, state visible
    rows_a[0] = '{tick_at(48'd0, 1'b1), 1'b1, 7'h7f, 48'd0};   // disabled
    rows_a[1] = '{tick_at(48'd0, 1'b1), 1'b1, 7'd0, 48'd0};
    rows_a[2] = '{tick_at(48'd1600, 1'b1), 1'b1, 7'd0, 48'd1};
    rows_a[3] = '{tick_at(48'd1600, 1'b0), 1'b1, 7'h7f, 48'd1}; // stopped
    foreach (rows_a[i]) begin
      if (i == 1) set_regs(1'b1, 32'd25600, 7'd16, 16'h0, 16'h0, 16'h0);
      send_req(rows_a[i].req);
      if (rows_a[i].typed && (trig_q[$].cur !== rows_a[i].cur || trig_q[$].cyc !== rows_a[i].cyc)) begin
        $display("%0t directed row %0d: expected %h/%h actual %h/%h", $time, i,
                 rows_a[i].cur, rows_a[i].cyc, trig_q[$].cur, trig_q[$].cyc);
        errors++;
      end
    end
    // valid channels are exactly those written at step 3
    set_regs(1'b1, 32'd25600, 7'd16, 16'h80a1, 16'h0, 16'h0);
    rows_b[0] = '{entry_wr(4'd0, 6'd3, 1'b1, sst_pkg::ProbFull, 8'hff), 1'b0, '0, '0};
    rows_b[1] = '{entry_wr(4'd15, 6'd3, 1'b1, 10'd0, 8'h00), 1'b0, '0, '0};
    rows_b[2] = '{entry_wr(4'd5, 6'd3, 1'b1, 10'd500, 8'h01), 1'b0, '0, '0};
    rows_b[3] = '{entry_wr(4'd7, 6'd3, 1'b0, sst_pkg::ProbFull, 8'h80), 1'b0, '0, '0};
    rows_b[4] = '{tick_at(48'd300, 1'b1), 1'b0, '0, '0};
    rows_b[5] = '{tick_at(48'd300, 1'b1), 1'b0, '0, '0};        // no retrigger
    rows_b[6] = '{tick_at(48'd350, 1'b1), 1'b0, '0, '0};        // between starts
    rows_b[7] = '{tick_at(48'hffff_ffff_ffff, 1'b1), 1'b0, '0, '0};
    rows_b[8] = '{tick_at(48'd1900, 1'b1), 1'b0, '0, '0};
    rows_b[9] = '{tick_at(48'd1600 * 48'd175921860443 + 48'd300, 1'b1), 1'b0, '0, '0};
    foreach (rows_b[i]) begin
      if (i == 8) set_regs(1'b1, 32'd25600, 7'd16, 16'h80a1, 16'h0001, 16'h0021);
      send_req(rows_b[i].req);
    end

    // random phases, each with its own register setting and idle pattern
    prev_pos = '0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(1'b1, 32'd256, 7'd64, FillMask, 16'h0, 16'h0);
        1: set_regs(1'b1, 32'hffff_ffff, 7'd64, FillMask, 16'($urandom), 16'h0);
        2: set_regs(1'b1, 32'd0, 7'd16, FillMask, 16'h0, 16'h0);
        3: set_regs(1'b1, 32'd512, 7'd0, FillMask, 16'h0, 16'h0);
        4: set_regs(1'b1, $urandom_range(256, 10240), 7'd127, 16'($urandom) & FillMask,
                    16'($urandom), 16'h0);
        5: set_regs(1'b0, 32'd300, 7'd8, FillMask, 16'h0, 16'h0);
        6: set_regs(1'b1, $urandom, 7'($urandom_range(64)), 16'($urandom) & FillMask,
                    16'($urandom), 16'($urandom));
        default: set_regs(1'b1, $urandom_range(256, 2048), 7'($urandom_range(1, 64)),
                          FillMask, 16'h0,
                          ($urandom_range(1) != 0) ? 16'h0 : 16'($urandom));
      endcase
      case (ph % 4)
        0: begin idle_pct_s = 0;  idle_pct_r = 0;  end
        1: begin idle_pct_s = 88; idle_pct_r = 0;  end
        2: begin idle_pct_s = 0;  idle_pct_r = 88; end
        default: begin idle_pct_s = 29; idle_pct_r = 29; end
      endcase
      for (int k = 0; k < RandItems; k++) begin
        if (ph == 2 && k == RandItems / 2) drain();   // hold off until all results are in
        r = rand_req(prev_pos);
        if (r.op == sst_pkg::OP_TICK) prev_pos = r.pos;
        send_req(r);
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && trig_q.size() == 0) begin
      $display("[step_sequencer_trigger] OK");
    end else begin
      $display("[step_sequencer_trigger] ERROR");
    end
    $finish;
  end

endmodule
